FILE: sv/dpp_pkg.sv
// Shared types and constants for the derivation path parser.
// Used by dpp_step, dpp_out_reg and derivation_path_parser_core; no dependencies.
package dpp_pkg;

    // ASCII codes the parser looks for.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_M          = 8'h6d;
    localparam logic [7:0] CH_SLASH      = 8'h2f;
    localparam logic [7:0] CH_APOSTROPHE = 8'h27;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;

    localparam logic [31:0] HARDENED_BIT = 32'h8000_0000;

    localparam int unsigned DEPTH_W = 4;
    localparam int unsigned INDEX_W = 32;
    localparam int unsigned TDATA_W = 40;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = 4'd10;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_EXPECT_M     = 3'd0,
        PH_EXPECT_SLASH = 3'd1,
        PH_COMP_START   = 3'd2,
        PH_DIGITS       = 3'd3,
        PH_AFTER_HARD   = 3'd4
    } phase_t;

    // Parser state carried from one character to the next.
    typedef struct packed {
        phase_t               phase;
        logic [INDEX_W-1:0]   acc;
        logic [DEPTH_W-1:0]   count;
        logic                 rejected;
    } parse_state_t;

    // One result item, plus the flag that says whether the character made one.
    typedef struct packed {
        logic                 emit;
        logic                 index_valid;
        logic [INDEX_W-1:0]   child_index;
        logic [DEPTH_W-1:0]   index_depth;
        logic                 path_done;
        logic                 accepted;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:    PH_EXPECT_M,
        acc:      '0,
        count:    '0,
        rejected: 1'b0
    };

endpackage

FILE: sv/derivation_path_parser_core.sv
// Derivation path parser, top level: takes one path character per transaction and
// returns each finished index and, at the zero byte, a verdict. Every character is
// handled by the combinational parser step feeding the result register, so a new
// transaction is taken each cycle while the consumer keeps up; the only stall comes
// from a full result register that is not being drained. A result appears in the cycle
// after the character that causes it. Depends on dpp_pkg, dpp_step and dpp_out_reg.
module derivation_path_parser_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dpp_pkg::DEPTH_W-1:0]   cfg_wr_data,    // depth_limit
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // character
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dpp_pkg::TDATA_W-1:0]   m_axis_tdata,   // index_valid, child_index[31:0],
                                                          // index_depth[3:0], accepted, 2'b0
    output logic                          m_axis_tlast    // path_done
);
    import dpp_pkg::*;

    logic [DEPTH_W-1:0]  depth_limit_reg;
    parse_state_t        state_reg;
    parse_state_t        state_next;
    parse_result_t       step_res;
    logic                in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_limit_reg <= DEPTH_LIMIT_RESET;
        else if (cfg_wr_en)
            depth_limit_reg <= cfg_wr_data;
    end

    // Parser step for the character on the input.
    dpp_step u_step
    (
        .character   (s_axis_tdata),
        .depth_limit (depth_limit_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    // Parser state advances on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (in_xfer)
            state_reg <= state_next;
    end

    dpp_out_reg u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_xfer),
        .load_res      (step_res),
        .load_ready    (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // A terminator rearms the parser.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (s_axis_tdata == CH_NUL)) |=>
            (state_reg.phase == PH_EXPECT_M) && (state_reg.count == '0) && !state_reg.rejected)
        else $error("parser not rearmed after terminator");

    // A terminator always yields a verdict in the next cycle.
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (s_axis_tdata == CH_NUL)) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("terminator did not produce a verdict");

    // The accepted flag only comes with a verdict.
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[37]) |-> m_axis_tlast)
        else $error("accepted set without path_done");

    // A carried index always has a nonzero depth.
    a_index_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[36:33] != '0))
        else $error("index emitted with zero depth");
`endif

endmodule

FILE: sv/dpp_step.sv
// Combinational parser step: next state and result for one character.
// Depends on dpp_pkg.
module dpp_step
(
    input  logic [7:0]                    character,
    input  logic [dpp_pkg::DEPTH_W-1:0]   depth_limit,
    input  dpp_pkg::parse_state_t         cur,
    output dpp_pkg::parse_state_t         nxt,
    output dpp_pkg::parse_result_t        res
);
    import dpp_pkg::*;

    logic                  is_digit;
    logic [INDEX_W-1:0]    digit_val;
    logic [INDEX_W-1:0]    acc_times_ten;
    logic [DEPTH_W-1:0]    count_inc;

    assign is_digit      = (character >= CH_ZERO) && (character <= CH_NINE);
    assign digit_val     = {{(INDEX_W-4){1'b0}}, character[3:0]};
    assign acc_times_ten = {cur.acc[INDEX_W-4:0], 3'b000} + {cur.acc[INDEX_W-2:0], 1'b0};
    assign count_inc     = cur.count + 1'b1;

    // Next state.
    always_comb
    begin
        nxt = cur;
        if (character == CH_NUL)
        begin
            nxt = STATE_RESET;
        end
        else if (!cur.rejected)
        begin
            unique case (cur.phase)
                PH_EXPECT_M:
                begin
                    if (character == CH_M)
                        nxt.phase = PH_EXPECT_SLASH;
                    else
                        nxt.rejected = 1'b1;
                end
                PH_EXPECT_SLASH:
                begin
                    if (character == CH_SLASH)
                        nxt.phase = PH_COMP_START;
                    else
                        nxt.rejected = 1'b1;
                end
                PH_COMP_START:
                begin
                    if ((cur.count >= depth_limit) || !is_digit)
                    begin
                        nxt.rejected = 1'b1;
                    end
                    else
                    begin
                        nxt.acc   = digit_val;
                        nxt.phase = PH_DIGITS;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        nxt.acc = acc_times_ten + digit_val;
                    end
                    else if (character == CH_APOSTROPHE)
                    begin
                        nxt.acc   = cur.acc | HARDENED_BIT;
                        nxt.phase = PH_AFTER_HARD;
                    end
                    else if (character == CH_SLASH)
                    begin
                        nxt.count = count_inc;
                        nxt.acc   = '0;
                        nxt.phase = PH_COMP_START;
                    end
                    else
                    begin
                        nxt.rejected = 1'b1;
                    end
                end
                PH_AFTER_HARD:
                begin
                    if (character == CH_SLASH)
                    begin
                        nxt.count = count_inc;
                        nxt.acc   = '0;
                        nxt.phase = PH_COMP_START;
                    end
                    else
                    begin
                        nxt.rejected = 1'b1;
                    end
                end
                default:
                begin
                    nxt.rejected = 1'b1;
                end
            endcase
        end
    end

    // Result for this character, if any. An unused phase code counts as a reject.
    always_comb
    begin
        res = '0;
        if (character == CH_NUL)
        begin
            res.emit        = 1'b1;
            res.path_done   = 1'b1;
            res.index_depth = cur.count;
            if (cur.rejected || (cur.phase == PH_EXPECT_M) || (cur.phase == PH_EXPECT_SLASH)
                || (cur.phase > PH_AFTER_HARD))
            begin
                res.accepted = 1'b0;
            end
            else if ((cur.phase == PH_DIGITS) || (cur.phase == PH_AFTER_HARD))
            begin
                res.index_valid = 1'b1;
                res.child_index = cur.acc;
                res.index_depth = count_inc;
                res.accepted    = 1'b1;
            end
            else
            begin
                res.accepted = 1'b1;
            end
        end
        else if (!cur.rejected && (character == CH_SLASH)
                 && ((cur.phase == PH_DIGITS) || (cur.phase == PH_AFTER_HARD)))
        begin
            res.emit        = 1'b1;
            res.index_valid = 1'b1;
            res.child_index = cur.acc;
            res.index_depth = count_inc;
        end
    end

endmodule

FILE: sv/dpp_out_reg.sv
// Result register with stream handshake toward the consumer.
// Depends on dpp_pkg.
module dpp_out_reg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  dpp_pkg::parse_result_t        load_res,
    output logic                          load_ready,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dpp_pkg::TDATA_W-1:0]   m_axis_tdata,   // index_valid, child_index[31:0],
                                                          // index_depth[3:0], accepted, 2'b0
    output logic                          m_axis_tlast    // path_done
);
    import dpp_pkg::*;

    logic           valid_reg;
    logic           valid_next;
    parse_result_t  res_reg;

    // A new result may enter when the register is empty or is drained this cycle.
    assign load_ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = load_res.emit;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load && load_res.emit)
            res_reg <= load_res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = res_reg.path_done;
    assign m_axis_tdata  = {2'b00, res_reg.accepted, res_reg.index_depth,
                            res_reg.child_index, res_reg.index_valid};

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for derivation_path_parser_core: feeds path characters through
// the input stream, predicts every index and verdict, and checks the output stream.
// Depends on dpp_pkg and derivation_path_parser_core.
`timescale 1ns / 1ps

module tb_top;
    import dpp_pkg::*;

    // Expected content of one result transaction.
    typedef struct packed {
        logic        index_valid;
        logic [31:0] child_index;
        logic [3:0]  index_depth;
        logic        path_done;
        logic        accepted;
    } path_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = 4'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Characters waiting to be sent and results waiting to be seen.
    logic [7:0]   path_chars[$];
    logic [7:0]   draft[$];
    path_result_t pending_results[$];

    // Shadow copy of the parser state and its register.
    phase_t      cur_phase = PH_EXPECT_M;
    logic [31:0] cur_acc = 32'd0;
    logic [3:0]  cur_count = 4'd0;
    logic        cur_rejected = 1'b0;
    logic [3:0]  cur_depth_limit = DEPTH_LIMIT_RESET;

    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;
    logic         long_stall_req = 1'b0;
    logic         long_stall_done = 1'b0;
    int           long_stall_cycles = 0;
    int           mismatches = 0;
    int           phase_chars;
    path_result_t want;
    path_result_t got;

    derivation_path_parser_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // Advance the shadow parser by one character and queue the result it causes.
    task automatic parse_char(input logic [7:0] c);
        logic         is_digit;
        logic         close_index;
        path_result_t r;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        close_index = 1'b0;
        r = '0;
        if (c == CH_NUL)
        begin
            r.path_done = 1'b1;
            r.index_depth = cur_count;
            if (cur_rejected || cur_phase == PH_EXPECT_M || cur_phase == PH_EXPECT_SLASH)
            begin
                r.accepted = 1'b0;
            end
            else if (cur_phase == PH_DIGITS || cur_phase == PH_AFTER_HARD)
            begin
                // The last index closes at the terminator and rides with the verdict.
                r.index_valid = 1'b1;
                r.child_index = cur_acc;
                r.index_depth = cur_count + 4'd1;
                r.accepted = 1'b1;
            end
            else
            begin
                r.accepted = 1'b1;
            end
            cur_phase = PH_EXPECT_M;
            cur_acc = 32'd0;
            cur_count = 4'd0;
            cur_rejected = 1'b0;
            pending_results.push_back(r);
        end
        else if (!cur_rejected)
        begin
            case (cur_phase)
                PH_EXPECT_M:
                begin
                    if (c == CH_M)
                        cur_phase = PH_EXPECT_SLASH;
                    else
                        cur_rejected = 1'b1;
                end
                PH_EXPECT_SLASH:
                begin
                    if (c == CH_SLASH)
                        cur_phase = PH_COMP_START;
                    else
                        cur_rejected = 1'b1;
                end
                PH_COMP_START:
                begin
                    if (cur_count >= cur_depth_limit || !is_digit)
                    begin
                        cur_rejected = 1'b1;
                    end
                    else
                    begin
                        cur_acc = 32'(c) - 32'(CH_ZERO);
                        cur_phase = PH_DIGITS;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        cur_acc = cur_acc * 32'd10 + (32'(c) - 32'(CH_ZERO));
                    end
                    else if (c == CH_APOSTROPHE)
                    begin
                        cur_acc = cur_acc | HARDENED_BIT;
                        cur_phase = PH_AFTER_HARD;
                    end
                    else if (c == CH_SLASH)
                        close_index = 1'b1;
                    else
                        cur_rejected = 1'b1;
                end
                default:
                begin
                    if (c == CH_SLASH)
                        close_index = 1'b1;
                    else
                        cur_rejected = 1'b1;
                end
            endcase
            if (close_index)
            begin
                cur_count = cur_count + 4'd1;
                r.index_valid = 1'b1;
                r.child_index = cur_acc;
                r.index_depth = cur_count;
                cur_acc = 32'd0;
                cur_phase = PH_COMP_START;
                pending_results.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Input driver: records each accepted character, then offers the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_char(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (path_chars.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    s_axis_tdata <= path_chars.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each result transaction and decides the next ready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.index_valid = m_axis_tdata[0];
                got.child_index = m_axis_tdata[32:1];
                got.index_depth = m_axis_tdata[36:33];
                got.accepted = m_axis_tdata[37];
                got.path_done = m_axis_tlast;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("index_valid", 32'(want.index_valid), 32'(got.index_valid));
                    check_field("child_index", want.child_index, got.child_index);
                    check_field("index_depth", 32'(want.index_depth), 32'(got.index_depth));
                    check_field("path_done", 32'(want.path_done), 32'(got.path_done));
                    check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                end
            end
            // A long hold-off lets the parser back up into its input.
            if (long_stall_req && !long_stall_done)
            begin
                m_axis_tready <= 1'b0;
                if (long_stall_cycles == 300)
                    long_stall_done <= 1'b1;
                else
                    long_stall_cycles <= long_stall_cycles + 1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            path_chars.push_back(s[i]);
        path_chars.push_back(CH_NUL);
    endtask

    // Well-formed body: m/ followed by components, now and then one too many.
    task automatic add_good_path();
        int n_comp;
        int n_dig;
        draft.push_back(CH_M);
        draft.push_back(CH_SLASH);
        n_comp = $urandom_range(0, cur_depth_limit);
        if ($urandom_range(0, 7) == 0)
            n_comp = cur_depth_limit + 1;
        for (int i = 0; i < n_comp; i++)
        begin
            n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
            repeat (n_dig)
                draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1)
                draft.push_back(CH_APOSTROPHE);
            if (i < n_comp - 1 || $urandom_range(0, 3) == 0)
                draft.push_back(CH_SLASH);
        end
    endtask

    // One terminated path: mostly well-formed, the rest noise, corrupted or cut short.
    task automatic add_random_path();
        int kind;
        int pos;
        draft.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 8))
                draft.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            add_good_path();
            if (kind < 16)
            begin
                pos = $urandom_range(0, draft.size() - 1);
                draft[pos] = 8'($urandom_range(1, 255));
            end
            else if (kind < 22)
            begin
                pos = $urandom_range(0, draft.size() - 1);
                while (draft.size() > pos)
                    draft.delete(draft.size() - 1);
            end
        end
        draft.push_back(CH_NUL);
        foreach (draft[i])
            path_chars.push_back(draft[i]);
        phase_chars += draft.size();
    endtask

    task automatic add_random_paths(input int count);
        phase_chars = 0;
        while (phase_chars < count)
            add_random_path();
    endtask

    task automatic wait_drained();
        while (path_chars.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Register writes happen only with the parser idle.
    task automatic write_depth_limit(input logic [3:0] depth);
        wait_drained();
        repeat (4) @(negedge clk);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= depth;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_depth_limit = depth;
        @(negedge clk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed paths at the reset depth: hardened index with trailing slash,
        // bad prefix on a 0xFF byte, early terminator, bare prefix, missing digits,
        // and a digit after the hardened mark.
        push_text("m/84'/0/");
        path_chars.push_back(8'hFF);
        path_chars.push_back(CH_NUL);
        push_text("m");
        push_text("m/");
        push_text("m//");
        push_text("m/9'5");

        write_depth_limit(4'd0);
        add_random_paths(145);

        write_depth_limit(4'd15);
        set_idling(63, 0);
        add_random_paths(145);

        write_depth_limit(4'd3);
        set_idling(0, 63);
        add_random_paths(145);
        long_stall_req = 1'b1;

        write_depth_limit(4'd1);
        set_idling(10, 10);
        add_random_paths(145);

        // The second half starts only after every result of the first has come.
        write_depth_limit(4'd6);
        set_idling(0, 0);
        add_random_paths(70);
        wait_drained();
        set_idling(10, 10);
        add_random_paths(75);

        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/dpp_pkg.sv
sv/dpp_step.sv
sv/dpp_out_reg.sv
sv/derivation_path_parser_core.sv
tb/tb_top.sv
